// ===== rtl/sparse_polynomial_adder_core_defines.svh =====
// assertion macros for the sparse polynomial adder
// used by rtl/sparse_polynomial_adder_core.sv, expects clock and reset in scope
`ifndef SPARSE_POLYNOMIAL_ADDER_CORE_DEFINES_SVH
`define SPARSE_POLYNOMIAL_ADDER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SPA_ASSERT_ALWAYS(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("sparse polynomial adder check failed");
`define SPA_ASSERT_IMPLIES(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sparse polynomial adder check failed");
`define SPA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sparse polynomial adder check failed");
`else
`define SPA_ASSERT_ALWAYS(lbl, cond)
`define SPA_ASSERT_IMPLIES(lbl, ante, cons)
`define SPA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/spa_pkg.sv =====
// types and constants of the sparse polynomial adder
// no dependencies
`default_nettype none
package spa_pkg;
   localparam int MAX_TERMS = 16;
   localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
   localparam int CNT_W = $clog2(MAX_TERMS + 1);

   // transaction modes
   localparam logic [1:0] MODE_INS_A  = 2'd0;
   localparam logic [1:0] MODE_INS_B  = 2'd1;
   localparam logic [1:0] MODE_SUM    = 2'd2;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   // result status codes
   localparam logic [2:0] ST_INSERTED = 3'd0;
   localparam logic [2:0] ST_COMBINED = 3'd1;
   localparam logic [2:0] ST_FULL     = 3'd2;
   localparam logic [2:0] ST_TERM     = 3'd3;
   localparam logic [2:0] ST_EMPTY    = 3'd4;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [31:0] coefficient;
      logic signed [31:0] exponent;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [31:0] term_coefficient;
      logic signed [31:0] term_exponent;
      logic               last;
   } rsp_type;
endpackage
`default_nettype wire

// ===== rtl/sparse_polynomial_adder_core.sv =====
// sparse polynomial adder: two sorted term tables, sorted insert and merge sum
// depends on spa_pkg and sparse_polynomial_adder_core_defines.svh
//
// usage: drive req_data and raise start; the transaction is taken when start is
// high and busy is low. modes 0 and 1 insert a term into table A or B, mode 2
// merges both tables, emits the sum terms and clears both tables, mode 3 is
// taken and ignored. results come out on rsp_data with a one-cycle rsp_valid
// strobe; rsp_data.last marks the final result of a transaction. the receiver
// cannot stall, so results are never held.
// an insert scans the table one entry a cycle and then shifts later entries up
// one a cycle; its single result follows the last step of work. a sum walks
// both tables in merge steps, taking the larger exponent or adding equal ones
// and dropping a zero sum; each term is held back until the next is made, and
// the held term goes out with last once both tables are done. one exponent
// comparator and one coefficient adder are shared by the scan and the merge
// steps. busy drops as the final result shows, and the next transaction can
// be taken in that cycle.
// reset clears both term counts and the sequencer; table contents need no clear.
`include "sparse_polynomial_adder_core_defines.svh"
`default_nettype none
module sparse_polynomial_adder_core
   import spa_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);
   typedef enum logic [2:0] {S_IDLE, S_SCAN, S_SHIFT, S_MERGE} state_type;

   state_type state_ff;
   logic              tsel_ff;
   logic signed [31:0] coef_ff, exp_ff;
   logic [CNT_W-1:0]  idx_ff, pos_ff, cnt_a_ff, cnt_b_ff, ia_ff, ib_ff;
   logic              pend_valid_ff;
   rsp_type           pend_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   logic signed [31:0] a_coef_ff [MAX_TERMS];
   logic signed [31:0] a_exp_ff  [MAX_TERMS];
   logic signed [31:0] b_coef_ff [MAX_TERMS];
   logic signed [31:0] b_exp_ff  [MAX_TERMS];

   logic [CNT_W-1:0] idx_m1, ra_in, rb_in, n_sel;
   logic signed [31:0] a_c, a_e, b_c, b_e, rd_c, rd_e;
   logic signed [31:0] op_x, op_y, sum, cx, cy;
   logic gt, eq, va, vb;
   logic prod_v;
   logic signed [31:0] prod_c, prod_e;
   logic [CNT_W-1:0] ia_in, ib_in;

   // read addresses, one per table
   always_comb begin
      idx_m1 = idx_ff - CNT_W'(1);
      if (state_ff == S_MERGE) begin
         ra_in = ia_ff;
         rb_in = ib_ff;
      end else if (state_ff == S_SHIFT) begin
         ra_in = idx_m1;
         rb_in = idx_m1;
      end else begin
         ra_in = idx_ff;
         rb_in = idx_ff;
      end
   end

   assign a_c  = a_coef_ff[ra_in[IDX_W-1:0]];
   assign a_e  = a_exp_ff[ra_in[IDX_W-1:0]];
   assign b_c  = b_coef_ff[rb_in[IDX_W-1:0]];
   assign b_e  = b_exp_ff[rb_in[IDX_W-1:0]];
   assign rd_c = tsel_ff ? b_c : a_c;
   assign rd_e = tsel_ff ? b_e : a_e;
   assign n_sel = tsel_ff ? cnt_b_ff : cnt_a_ff;

   // shared adder and exponent comparator
   always_comb begin
      if (state_ff == S_MERGE) begin
         op_x = a_c;
         op_y = b_c;
         cx   = a_e;
         cy   = b_e;
      end else begin
         op_x = rd_c;
         op_y = coef_ff;
         cx   = rd_e;
         cy   = exp_ff;
      end
      sum = op_x + op_y;
      gt  = cx > cy;
      eq  = cx == cy;
   end

   // one merge step
   always_comb begin
      va     = ia_ff < cnt_a_ff;
      vb     = ib_ff < cnt_b_ff;
      prod_v = 1'b0;
      prod_c = a_c;
      prod_e = a_e;
      ia_in  = ia_ff;
      ib_in  = ib_ff;
      if (va && vb && eq) begin
         prod_v = sum != 32'sd0;
         prod_c = sum;
         ia_in  = ia_ff + CNT_W'(1);
         ib_in  = ib_ff + CNT_W'(1);
      end else if (va && (!vb || gt)) begin
         prod_v = 1'b1;
         ia_in  = ia_ff + CNT_W'(1);
      end else if (vb) begin
         prod_v = 1'b1;
         prod_c = b_c;
         prod_e = b_e;
         ib_in  = ib_ff + CNT_W'(1);
      end
   end

   // sequencer, tables and registered result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_a_ff      <= '0;
         cnt_b_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  coef_ff <= req_data.coefficient;
                  exp_ff  <= req_data.exponent;
                  tsel_ff <= req_data.mode == MODE_INS_B;
                  idx_ff  <= '0;
                  ia_ff   <= '0;
                  ib_ff   <= '0;
                  if (req_data.mode == MODE_INS_A || req_data.mode == MODE_INS_B)
                     state_ff <= S_SCAN;
                  else if (req_data.mode == MODE_SUM)
                     state_ff <= S_MERGE;
               end
            end
            S_SCAN: begin
               rsp_ff.term_coefficient <= coef_ff;
               rsp_ff.term_exponent    <= exp_ff;
               rsp_ff.last             <= 1'b1;
               if (idx_ff < n_sel && gt) begin
                  idx_ff <= idx_ff + CNT_W'(1);
               end else if (idx_ff < n_sel && eq) begin
                  if (tsel_ff) b_coef_ff[idx_ff[IDX_W-1:0]] <= sum;
                  else         a_coef_ff[idx_ff[IDX_W-1:0]] <= sum;
                  rsp_ff.status <= ST_COMBINED;
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= S_IDLE;
               end else if (n_sel >= CNT_W'(MAX_TERMS)) begin
                  rsp_ff.status <= ST_FULL;
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= S_IDLE;
               end else begin
                  pos_ff   <= idx_ff;
                  idx_ff   <= n_sel;
                  state_ff <= S_SHIFT;
               end
            end
            S_SHIFT: begin
               if (idx_ff > pos_ff) begin
                  // move one entry up
                  if (tsel_ff) begin
                     b_coef_ff[idx_ff[IDX_W-1:0]] <= rd_c;
                     b_exp_ff[idx_ff[IDX_W-1:0]]  <= rd_e;
                  end else begin
                     a_coef_ff[idx_ff[IDX_W-1:0]] <= rd_c;
                     a_exp_ff[idx_ff[IDX_W-1:0]]  <= rd_e;
                  end
                  idx_ff <= idx_m1;
               end else begin
                  if (tsel_ff) begin
                     b_coef_ff[pos_ff[IDX_W-1:0]] <= coef_ff;
                     b_exp_ff[pos_ff[IDX_W-1:0]]  <= exp_ff;
                     cnt_b_ff <= cnt_b_ff + CNT_W'(1);
                  end else begin
                     a_coef_ff[pos_ff[IDX_W-1:0]] <= coef_ff;
                     a_exp_ff[pos_ff[IDX_W-1:0]]  <= exp_ff;
                     cnt_a_ff <= cnt_a_ff + CNT_W'(1);
                  end
                  rsp_ff.status <= ST_INSERTED;
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= S_IDLE;
               end
            end
            S_MERGE: begin
               ia_ff <= ia_in;
               ib_ff <= ib_in;
               if (!va && !vb) begin
                  // flush the held term as last, or report an empty sum
                  if (pend_valid_ff) begin
                     rsp_ff      <= pend_ff;
                     rsp_ff.last <= 1'b1;
                  end else begin
                     rsp_ff.status           <= ST_EMPTY;
                     rsp_ff.term_coefficient <= '0;
                     rsp_ff.term_exponent    <= '0;
                     rsp_ff.last             <= 1'b1;
                  end
                  rsp_valid_ff  <= 1'b1;
                  pend_valid_ff <= 1'b0;
                  cnt_a_ff      <= '0;
                  cnt_b_ff      <= '0;
                  state_ff      <= S_IDLE;
               end else if (prod_v) begin
                  // hold one term back so the final one can carry last
                  if (pend_valid_ff) begin
                     rsp_ff       <= pend_ff;
                     rsp_valid_ff <= 1'b1;
                  end
                  pend_ff.status           <= ST_TERM;
                  pend_ff.term_coefficient <= prod_c;
                  pend_ff.term_exponent    <= prod_e;
                  pend_ff.last             <= 1'b0;
                  pend_valid_ff            <= 1'b1;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   `SPA_ASSERT_ALWAYS(a_cnt_bound, cnt_a_ff <= CNT_W'(MAX_TERMS) && cnt_b_ff <= CNT_W'(MAX_TERMS))
   `SPA_ASSERT_NEXT(a_start_busy, start && !busy && req_data.mode != MODE_UNUSED, busy)
   `SPA_ASSERT_IMPLIES(a_empty_last, rsp_valid && rsp_data.status == ST_EMPTY, rsp_data.last)
   `SPA_ASSERT_IMPLIES(a_idle_no_pend, state_ff == S_IDLE, !pend_valid_ff)
   `SPA_ASSERT_IMPLIES(a_insert_last, rsp_valid && rsp_data.status != ST_TERM, rsp_data.last)
endmodule
`default_nettype wire
